// ===== rtl/srpf_pkg.sv =====
package srpf_pkg;

   localparam int RANGE_DEPTH = 1024;
   localparam int ADDR_W      = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(RANGE_DEPTH + 1);
   localparam int OP_W        = 2;
   localparam int POS_W       = 40;
   localparam int ID_W        = 31;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_FILTER = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FETCH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // input word taken this cycle
      logic fetch;    // read table entry at the pointer
      logic load;     // move read data into the current-range cache
      logic advance;  // step pointer past the current range
      logic emit;     // load the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_filter;
      logic tbl_empty;
      logic ptr_end;
      logic cur_valid;
      logic pos_ge_stop;
      logic pos_lt_start;
      logic rsp_busy;
   } status_type;

endpackage

// ===== rtl/srpf_if.sv =====
interface srpf_req_if;
   import srpf_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [POS_W-1:0]    range_start;
   logic [POS_W-1:0]    range_stop;
   logic [POS_W-1:0]    position;
   logic [ID_W-1:0]     token_id;

   modport source (output valid, operation, range_start, range_stop, position, token_id,
                   input ready);
   modport sink   (input valid, operation, range_start, range_stop, position, token_id,
                   output ready);
endinterface

interface srpf_rsp_if;
   import srpf_pkg::*;
   logic                valid;
   logic                ready;
   logic [POS_W-1:0]    kept_position;
   logic [ID_W-1:0]     kept_id;
   logic [POS_W-1:0]    offset;

   modport source (output valid, kept_position, kept_id, offset, input ready);
   modport sink   (input valid, kept_position, kept_id, offset, output ready);
endinterface

// ===== rtl/sorted_range_position_filter_unit.sv =====
// Sorted range position filter. Load a table of sorted, disjoint ranges
// [range_start, range_stop) with append words (up to 1024; further appends
// are dropped), then stream ascending (position, token_id) filter words. A
// word inside the current range comes out with offset = first range start
// plus all gaps skipped so far; subtract it to get the subcorpus position.
// Words before the current range, after the last range, or sent to an empty
// table give no response. A clear word empties the table and zeroes the
// pointer and offset; operation code 3 is ignored. Steps: append, clear and
// unknown words, and filter words sent to an empty table, are taken while
// idle and leave the block ready; a filter word is accepted, then evaluated
// and emitted when it lands on the current range, with an advance, fetch
// and load step for every range the pointer moves past, since each new
// entry comes from the single-port table RAM with a registered read;
// stepping off the last range takes only the advance step. Between clears
// the pointer only moves forward. Results sit in an output register, so a
// new word is taken while a response still waits; a filter word that needs
// to emit while the register is full holds until rsp.ready.
module sorted_range_position_filter_unit
   import srpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   srpf_req_if.sink   req,
   srpf_rsp_if.source rsp
);

   cmd_type    cmd;
   status_type status;
   logic       ready;

   // state machine: sequences accept / fetch / evaluate / emit
   srpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   // range table RAM, pointer, running offset, current-range cache, rsp register
   srpf_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req.operation),
      .req_range_start (req.range_start),
      .req_range_stop  (req.range_stop),
      .req_position    (req.position),
      .req_token_id    (req.token_id),
      .rsp             (rsp)
   );

   assign req.ready = ready;

endmodule

// ===== rtl/srpf_ctrl.sv =====
module srpf_ctrl
   import srpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.is_filter && !status.tbl_empty) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            if (status.ptr_end) begin
               state_in = ST_IDLE;          // ranges exhausted: drop
            end else if (!status.cur_valid) begin
               cmd.fetch = 1'b1;
               state_in  = ST_FETCH;
            end else if (status.pos_ge_stop) begin
               cmd.advance = 1'b1;
            end else if (status.pos_lt_start) begin
               state_in = ST_IDLE;          // before current range: drop
            end else if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            cmd.load = 1'b1;
            state_in = ST_EVAL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/srpf_dpath.sv =====
module srpf_dpath
   import srpf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [OP_W-1:0]  req_operation,
   input  logic [POS_W-1:0] req_range_start,
   input  logic [POS_W-1:0] req_range_stop,
   input  logic [POS_W-1:0] req_position,
   input  logic [ID_W-1:0]  req_token_id,
   srpf_rsp_if.source       rsp
);

   // range table: start in the upper half, stop in the lower half
   logic [2*POS_W-1:0] table_mem [RANGE_DEPTH];
   logic [2*POS_W-1:0] rd_q_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   pointer_ff, pointer_in;
   logic [POS_W-1:0]   gap_ff, gap_in;
   logic [POS_W-1:0]   last_stop_ff, last_stop_in;
   logic [POS_W-1:0]   pend_stop_ff, pend_stop_in;
   logic               pend_ff, pend_in;
   logic [POS_W-1:0]   cur_start_ff, cur_start_in;
   logic [POS_W-1:0]   cur_stop_ff, cur_stop_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [POS_W-1:0]   rsp_off_ff, rsp_off_in;

   logic               do_append;
   logic               do_clear;
   logic               do_filter;

   assign do_append = cmd.accept && (req_operation == OP_APPEND)
                      && (count_ff < CNT_W'(RANGE_DEPTH));
   assign do_clear  = cmd.accept && (req_operation == OP_CLEAR);
   assign do_filter = cmd.accept && (req_operation == OP_FILTER);

   always_ff @(posedge clock) begin
      if (do_append) begin
         table_mem[count_ff[ADDR_W-1:0]] <= {req_range_start, req_range_stop};
      end
      if (cmd.fetch) begin
         rd_q_ff <= table_mem[pointer_ff[ADDR_W-1:0]];
      end
   end

   always_comb begin
      count_in     = count_ff;
      pointer_in   = pointer_ff;
      gap_in       = gap_ff;
      last_stop_in = last_stop_ff;
      pend_stop_in = pend_stop_ff;
      pend_in      = pend_ff;
      cur_start_in = cur_start_ff;
      cur_stop_in  = cur_stop_ff;
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      id_in        = id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_off_in   = rsp_off_ff;

      if (do_filter) begin
         pos_in = req_position;
         id_in  = req_token_id;
      end

      if (do_append) begin
         count_in     = count_ff + CNT_W'(1);
         last_stop_in = req_range_stop;
         if (pointer_ff == count_ff) begin
            // new range becomes the current one
            cur_start_in = req_range_start;
            cur_stop_in  = req_range_stop;
            cur_valid_in = 1'b1;
            pend_in      = 1'b0;
            if (count_ff == '0) begin
               gap_in = req_range_start;
            end else begin
               gap_in = gap_ff + req_range_start - last_stop_ff;
            end
         end
      end

      if (do_clear) begin
         count_in     = '0;
         pointer_in   = '0;
         gap_in       = '0;
         pend_in      = 1'b0;
         cur_valid_in = 1'b0;
      end

      if (cmd.advance) begin
         pointer_in   = pointer_ff + CNT_W'(1);
         cur_valid_in = 1'b0;
         pend_in      = 1'b1;
         pend_stop_in = cur_stop_ff;
      end

      if (cmd.load) begin
         cur_start_in = rd_q_ff[2*POS_W-1:POS_W];
         cur_stop_in  = rd_q_ff[POS_W-1:0];
         cur_valid_in = 1'b1;
         pend_in      = 1'b0;
         if (pend_ff) begin
            gap_in = gap_ff + rd_q_ff[2*POS_W-1:POS_W] - pend_stop_ff;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = pos_ff;
         rsp_id_in    = id_ff;
         rsp_off_in   = gap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pointer_ff   <= '0;
         gap_ff       <= '0;
         pend_ff      <= 1'b0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pointer_ff   <= pointer_in;
         gap_ff       <= gap_in;
         pend_ff      <= pend_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_stop_ff <= last_stop_in;
      pend_stop_ff <= pend_stop_in;
      cur_start_ff <= cur_start_in;
      cur_stop_ff  <= cur_stop_in;
      pos_ff       <= pos_in;
      id_ff        <= id_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_off_ff   <= rsp_off_in;
   end

   always_comb begin
      status.is_filter    = (req_operation == OP_FILTER);
      status.tbl_empty    = (count_ff == '0);
      status.ptr_end      = (pointer_ff >= count_ff);
      status.cur_valid    = cur_valid_ff;
      status.pos_ge_stop  = (pos_ff >= cur_stop_ff);
      status.pos_lt_start = (pos_ff < cur_start_ff);
      status.rsp_busy     = rsp_valid_ff && !rsp.ready;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kept_position = rsp_pos_ff;
   assign rsp.kept_id       = rsp_id_ff;
   assign rsp.offset        = rsp_off_ff;

endmodule

// ===== rtl/srpf_checker.sv =====
module srpf_checker
   import srpf_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [POS_W-1:0] rsp_kept_position,
   input logic [ID_W-1:0]  rsp_kept_id,
   input logic [POS_W-1:0] rsp_offset
);

   // response word held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped before taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_kept_position) && $stable(rsp_kept_id) && $stable(rsp_offset))
      else $error("stalled rsp word changed");

   // nothing pending out of reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   // a response is produced only while the block is evaluating, never while idle
   a_rsp_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("rsp word appeared without evaluation cycle");

endmodule

bind sorted_range_position_filter_unit srpf_checker u_srpf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_kept_position (rsp.kept_position),
   .rsp_kept_id       (rsp.kept_id),
   .rsp_offset        (rsp.offset)
);
